// File: src/bmhpq_pkg.sv
// Shared types and constants for the binary max-heap priority queue.
package bmhpq_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int VALUE_W      = 32;
    localparam int ACTION_W     = 2;
    localparam int STATUS_W     = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT  = 2'd0,
        ACT_EXTRACT = 2'd1,
        ACT_FINDMIN = 2'd2,
        ACT_NOP     = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_EX_ROOT,
        S_EX_LAST,
        S_EX_HOLD,
        S_DN_RL,
        S_DN_RR,
        S_DN_CMP,
        S_FM
    } t_state;

endpackage

// File: src/bmhpq_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
module bmhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/binary_max_heap_priority_queue.sv
// Status errors and the unused action are answered from idle; insert sifts the new value up
// to the root or until it stops; extract reads the root and the last entry, then sifts down
// to a leaf or until it stops; find-min scans the leaves. Results cannot be stalled.
// Throughput: one item at a time; busy falls as the strobe rises, so the next transfer can
// share the result's edge. Reset: synchronous active-low, empties the heap; RAM not cleared.
module binary_max_heap_priority_queue #(
    parameter int CAPACITY = bmhpq_pkg::DEF_CAPACITY
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [bmhpq_pkg::ACTION_W-1:0]         i_action,
    input  logic signed [bmhpq_pkg::VALUE_W-1:0]   i_value,
    output logic                                   o_valid,
    output logic signed [bmhpq_pkg::VALUE_W-1:0]   o_result_value,
    output logic [bmhpq_pkg::STATUS_W-1:0]         o_status
);
    import bmhpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_idx, n_idx;
    logic signed [VALUE_W-1:0] r_hold, n_hold;
    logic signed [VALUE_W-1:0] r_left, n_left;
    logic signed [VALUE_W-1:0] r_min, n_min;
    logic signed [VALUE_W-1:0] r_res, n_res;
    logic r_have, n_have;
    logic r_pend, n_pend;
    logic r_out_valid, n_out_valid;
    logic signed [VALUE_W-1:0] r_out_value, n_out_value;
    logic [STATUS_W-1:0] r_out_status, n_out_status;

    logic accept;
    logic is_full, is_empty;
    logic [IW-1:0] pos_ext, cnt_ext, l_idx, rt_idx;
    logic has_l, has_r;
    logic [AW-1:0] parent;
    logic signed [VALUE_W-1:0] rd_data, big_val;
    logic up_swap, take_l, take_r;
    logic fm_issue, fm_take, fm_end;
    logic signed [VALUE_W-1:0] fm_min;

    logic ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [VALUE_W-1:0] ram_wdata, ram_rdata;

    bmhpq_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(CAPACITY)
    ) u_heap_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign rd_data  = ram_rdata;
    assign accept   = start && !busy;
    assign is_full  = r_count == CW'(CAPACITY);
    assign is_empty = r_count == '0;

    // child and parent positions
    assign pos_ext = IW'(r_pos);
    assign cnt_ext = IW'(r_count);
    assign l_idx   = (pos_ext << 1) + IW'(1);
    assign rt_idx  = l_idx + IW'(1);
    assign has_l   = l_idx < cnt_ext;
    assign has_r   = rt_idx < cnt_ext;
    assign parent  = (r_pos - AW'(1)) >> 1;

    assign up_swap = r_hold > rd_data;
    // tie between children goes left, tie with the moving value stays put
    assign take_l  = has_l && (r_left > r_hold);
    assign big_val = take_l ? r_left : r_hold;
    assign take_r  = has_r && (rd_data > big_val);

    // leaf scan, one read issued per cycle, each compared in the following cycle
    assign fm_issue = r_idx < r_count;
    assign fm_take  = r_pend && (!r_have || (rd_data < r_min));
    assign fm_min   = fm_take ? rd_data : r_min;
    assign fm_end   = !fm_issue && !r_pend;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (t_action'(i_action))
                        ACT_INSERT:  n_state = is_full  ? S_IDLE : S_UP_RD;
                        ACT_EXTRACT: n_state = is_empty ? S_IDLE : S_EX_ROOT;
                        ACT_FINDMIN: n_state = is_empty ? S_IDLE : S_FM;
                        ACT_NOP:     n_state = S_IDLE;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_UP_RD:   n_state = (r_pos == '0) ? S_IDLE : S_UP_CMP;
            S_UP_CMP:  n_state = up_swap ? S_UP_RD : S_IDLE;
            S_EX_ROOT: n_state = S_EX_LAST;
            S_EX_LAST: n_state = S_EX_HOLD;
            S_EX_HOLD: n_state = is_empty ? S_IDLE : S_DN_RL;
            S_DN_RL:   n_state = has_l ? S_DN_RR : S_IDLE;
            S_DN_RR:   n_state = S_DN_CMP;
            S_DN_CMP:  n_state = (take_l || take_r) ? S_DN_RL : S_IDLE;
            S_FM:      n_state = fm_end ? S_IDLE : S_FM;
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath registers and result
    always_comb begin
        n_count      = r_count;
        n_pos        = r_pos;
        n_idx        = r_idx;
        n_hold       = r_hold;
        n_left       = r_left;
        n_min        = r_min;
        n_res        = r_res;
        n_have       = r_have;
        n_pend       = 1'b0;
        n_out_valid  = 1'b0;
        n_out_value  = '0;
        n_out_status = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (t_action'(i_action))
                        ACT_INSERT: begin
                            if (is_full) begin
                                n_out_valid  = 1'b1;
                                n_out_status = ST_FULL;
                            end else begin
                                n_hold  = i_value;
                                n_pos   = r_count[AW-1:0];
                                n_count = r_count + CW'(1);
                            end
                        end
                        ACT_EXTRACT: begin
                            if (is_empty) begin
                                n_out_valid  = 1'b1;
                                n_out_status = ST_EMPTY;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        ACT_FINDMIN: begin
                            if (is_empty) begin
                                n_out_valid  = 1'b1;
                                n_out_status = ST_EMPTY;
                            end else begin
                                n_idx  = r_count >> 1;
                                n_have = 1'b0;
                            end
                        end
                        ACT_NOP:  n_out_valid = 1'b1;
                        default:  n_out_valid = 1'b1;
                    endcase
                end
            end
            S_UP_RD: begin
                n_out_valid = r_pos == '0;
            end
            S_UP_CMP: begin
                if (up_swap) begin
                    n_pos = parent;
                end else begin
                    n_out_valid = 1'b1;
                end
            end
            S_EX_LAST: begin
                n_res = rd_data;
            end
            S_EX_HOLD: begin
                n_hold = rd_data;
                n_pos  = '0;
                if (is_empty) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_res;
                end
            end
            S_DN_RL: begin
                if (!has_l) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_res;
                end
            end
            S_DN_RR: begin
                n_left = rd_data;
            end
            S_DN_CMP: begin
                if (take_r) begin
                    n_pos = rt_idx[AW-1:0];
                end else if (take_l) begin
                    n_pos = l_idx[AW-1:0];
                end else begin
                    n_out_valid = 1'b1;
                    n_out_value = r_res;
                end
            end
            S_FM: begin
                n_pend = fm_issue;
                n_min  = fm_min;
                if (r_pend) begin
                    n_have = 1'b1;
                end
                if (fm_issue) begin
                    n_idx = r_idx + CW'(1);
                end
                if (fm_end) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_min;
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    // RAM port controls
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_pos;
        ram_wdata = r_hold;
        ram_re    = 1'b0;
        ram_raddr = '0;
        case (r_state)
            S_UP_RD: begin
                if (r_pos == '0) begin
                    ram_we = 1'b1;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = parent;
                end
            end
            S_UP_CMP: begin
                ram_we    = 1'b1;
                ram_wdata = up_swap ? rd_data : r_hold;
            end
            S_EX_ROOT: begin
                ram_re = 1'b1;
            end
            S_EX_LAST: begin
                ram_re    = 1'b1;
                ram_raddr = r_count[AW-1:0];
            end
            S_DN_RL: begin
                if (has_l) begin
                    ram_re    = 1'b1;
                    ram_raddr = l_idx[AW-1:0];
                end else begin
                    ram_we = 1'b1;
                end
            end
            S_DN_RR: begin
                ram_re    = has_r;
                ram_raddr = rt_idx[AW-1:0];
            end
            S_DN_CMP: begin
                ram_we = 1'b1;
                if (take_r) begin
                    ram_wdata = rd_data;
                end else if (take_l) begin
                    ram_wdata = r_left;
                end
            end
            S_FM: begin
                ram_re    = fm_issue;
                ram_raddr = r_idx[AW-1:0];
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_have      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
            r_have      <= n_have;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_idx        <= n_idx;
        r_hold       <= n_hold;
        r_left       <= n_left;
        r_min        <= n_min;
        r_res        <= n_res;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    assign busy           = r_state != S_IDLE;
    assign o_valid        = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_status       = r_out_status;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_strobe_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(start && !busy) || $past(busy)))
        else $error("result strobe without a transfer in progress");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_action == ACT_INSERT) && !is_full) |=>
            (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the heap");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_FULL)) |-> is_full)
        else $error("full status with room left");

    a_ram_hazard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("read and write of the same heap entry in one cycle");
`endif

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the binary max-heap priority queue.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bmhpq_pkg::*;

    localparam int CAPACITY     = DEF_CAPACITY;
    localparam int N_RANDOM     = 1200;
    localparam int N_PHASES     = 4;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 64;
    localparam int MAX_REPORTS  = 10;

    localparam logic signed [VALUE_W-1:0] VAL_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VAL_MIN  = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_ZERO = 32'sd0;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        t_status                   status;
    } t_heap_result;

    typedef struct packed {
        t_action                   action;
        logic signed [VALUE_W-1:0] value;
        bit                        fixed;
        logic signed [VALUE_W-1:0] exp_value;
        t_status                   exp_status;
    } t_op_row;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic [ACTION_W-1:0]         i_action;
    logic signed [VALUE_W-1:0]   i_value;
    logic                        o_valid;
    logic signed [VALUE_W-1:0]   o_result_value;
    logic [STATUS_W-1:0]         o_status;

    // Predictor state
    logic signed [VALUE_W-1:0]   heap_model [CAPACITY];
    int                          heap_count;

    t_heap_result                pending_results [$];
    t_op_row                     op_table [$];
    int                          error_count;
    int                          cycle_count;
    int                          idle_pct;
    bit                          filling;
    t_heap_result                got_result;

    binary_max_heap_priority_queue #(
        .CAPACITY(CAPACITY)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .o_result_value (o_result_value),
        .o_status       (o_status)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic void predict_heap_op(
        input  t_action                   act,
        input  logic signed [VALUE_W-1:0] val,
        output logic signed [VALUE_W-1:0] res,
        output t_status                   st
    );
        int                        pos;
        int                        parent;
        int                        big;
        int                        idx;
        logic signed [VALUE_W-1:0] tmp;
        res = VAL_ZERO;
        st  = ST_OK;
        case (act)
            ACT_INSERT: begin
                if (heap_count >= CAPACITY) begin
                    st = ST_FULL;
                end else begin
                    heap_model[heap_count] = val;
                    pos = heap_count;
                    heap_count++;
                    while (pos > 0) begin
                        parent = (pos - 1) / 2;
                        if (heap_model[pos] > heap_model[parent]) begin
                            tmp                = heap_model[pos];
                            heap_model[pos]    = heap_model[parent];
                            heap_model[parent] = tmp;
                            pos                = parent;
                        end else begin
                            break;
                        end
                    end
                end
            end
            ACT_EXTRACT: begin
                if (heap_count == 0) begin
                    st = ST_EMPTY;
                end else begin
                    res = heap_model[0];
                    heap_count--;
                    heap_model[0] = heap_model[heap_count];
                    pos = 0;
                    while (pos < heap_count) begin
                        big = pos;
                        // strict compare: ties keep the parent, then the left child
                        if (2*pos+1 < heap_count && heap_model[2*pos+1] > heap_model[big])
                            big = 2*pos+1;
                        if (2*pos+2 < heap_count && heap_model[2*pos+2] > heap_model[big])
                            big = 2*pos+2;
                        if (big == pos)
                            break;
                        tmp             = heap_model[pos];
                        heap_model[pos] = heap_model[big];
                        heap_model[big] = tmp;
                        pos             = big;
                    end
                end
            end
            ACT_FINDMIN: begin
                if (heap_count == 0) begin
                    st = ST_EMPTY;
                end else begin
                    res = heap_model[heap_count/2];
                    for (idx = heap_count/2 + 1; idx < heap_count; idx++) begin
                        if (heap_model[idx] < res)
                            res = heap_model[idx];
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    task automatic report_error(input string msg);
        if (error_count < MAX_REPORTS)
            $display("%s", msg);
        error_count++;
    endtask

    task automatic table_row(
        input t_action                   act,
        input logic signed [VALUE_W-1:0] val,
        input bit                        fixed,
        input logic signed [VALUE_W-1:0] ev,
        input t_status                   es
    );
        t_op_row row;
        row.action     = act;
        row.value      = val;
        row.fixed      = fixed;
        row.exp_value  = ev;
        row.exp_status = es;
        op_table = {op_table, row};
    endtask

    // Presents one command, waits for its transfer, then records the expected result.
    task automatic issue_op(
        input t_action                   act,
        input logic signed [VALUE_W-1:0] val,
        input bit                        fixed,
        input logic signed [VALUE_W-1:0] ev,
        input t_status                   es
    );
        logic signed [VALUE_W-1:0] pred_value;
        t_status                   pred_status;
        t_heap_result              r;
        while ($urandom_range(0, 99) < idle_pct) begin
            start    <= 1'b0;
            i_action <= ACTION_W'($urandom);
            i_value  <= $urandom;
            @(posedge i_clk);
        end
        start    <= 1'b1;
        i_action <= act;
        i_value  <= val;
        do @(posedge i_clk); while (busy);
        predict_heap_op(act, val, pred_value, pred_status);
        r.value  = fixed ? ev : pred_value;
        r.status = fixed ? es : pred_status;
        pending_results = {pending_results, r};
    endtask

    task automatic random_op();
        int                        pick;
        t_action                   act;
        logic signed [VALUE_W-1:0] val;
        // alternate long fill and drain runs so full and empty are both hit often
        if (heap_count >= CAPACITY && $urandom_range(0, 3) == 0)
            filling = 1'b0;
        else if (heap_count == 0 && $urandom_range(0, 3) == 0)
            filling = 1'b1;
        else if ($urandom_range(0, 49) == 0)
            filling = !filling;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            act = ACT_NOP;
        else if (pick < 18)
            act = ACT_FINDMIN;
        else if (pick < (filling ? 85 : 35))
            act = ACT_INSERT;
        else
            act = ACT_EXTRACT;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0:       val = VAL_MAX;
                    1:       val = VAL_MIN;
                    2:       val = VAL_ZERO;
                    default: val = -32'sd1;
                endcase
            end
            1, 2, 3: val = $signed($urandom_range(0, 15)) - 32'sd8;
            default: val = $urandom;
        endcase
        issue_op(act, val, 1'b0, VAL_ZERO, ST_OK);
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                report_error($sformatf("unexpected result: value %0d status %0d",
                                       o_result_value, o_status));
            end else begin
                got_result = pending_results.pop_front();
                if (o_result_value !== got_result.value || o_status !== got_result.status)
                    report_error($sformatf(
                        "mismatch: expected value %0d status %0d, got value %0d status %0d",
                        got_result.value, got_result.status, o_result_value, o_status));
            end
        end
    end

    initial begin
        error_count = 0;
        cycle_count = 0;
        heap_count  = 0;
        idle_pct    = 0;
        filling     = 1'b1;
        i_rst_n  <= 1'b0;
        start    <= 1'b0;
        i_action <= ACT_NOP;
        i_value  <= VAL_ZERO;

        // empty-heap errors, unused code, extremes, equal keys, drain back to empty
        table_row(ACT_EXTRACT, VAL_ZERO,       1'b1, VAL_ZERO, ST_EMPTY);
        table_row(ACT_FINDMIN, VAL_ZERO,       1'b1, VAL_ZERO, ST_EMPTY);
        table_row(ACT_NOP,     32'sh5A5A_5A5A, 1'b1, VAL_ZERO, ST_OK);
        table_row(ACT_INSERT,  VAL_MAX,        1'b1, VAL_ZERO, ST_OK);
        table_row(ACT_INSERT,  VAL_MIN,        1'b1, VAL_ZERO, ST_OK);
        table_row(ACT_FINDMIN, VAL_MAX,        1'b0, VAL_ZERO, ST_OK);
        table_row(ACT_INSERT,  VAL_ZERO,       1'b0, VAL_ZERO, ST_OK);
        table_row(ACT_INSERT,  -32'sd1,        1'b0, VAL_ZERO, ST_OK);
        table_row(ACT_INSERT,  32'sd5,         1'b0, VAL_ZERO, ST_OK);
        table_row(ACT_INSERT,  32'sd5,         1'b0, VAL_ZERO, ST_OK);
        table_row(ACT_INSERT,  32'sd5,         1'b0, VAL_ZERO, ST_OK);
        table_row(ACT_FINDMIN, -32'sd1,        1'b0, VAL_ZERO, ST_OK);
        table_row(ACT_NOP,     -32'sd1,        1'b1, VAL_ZERO, ST_OK);
        table_row(ACT_EXTRACT, VAL_MIN,        1'b1, VAL_MAX,  ST_OK);
        table_row(ACT_EXTRACT, VAL_ZERO,       1'b0, VAL_ZERO, ST_OK);
        table_row(ACT_EXTRACT, VAL_ZERO,       1'b0, VAL_ZERO, ST_OK);
        table_row(ACT_FINDMIN, VAL_ZERO,       1'b0, VAL_ZERO, ST_OK);
        table_row(ACT_INSERT,  32'sd5,         1'b0, VAL_ZERO, ST_OK);
        table_row(ACT_EXTRACT, VAL_ZERO,       1'b0, VAL_ZERO, ST_OK);
        table_row(ACT_EXTRACT, VAL_ZERO,       1'b0, VAL_ZERO, ST_OK);
        table_row(ACT_EXTRACT, VAL_ZERO,       1'b0, VAL_ZERO, ST_OK);
        table_row(ACT_EXTRACT, VAL_ZERO,       1'b0, VAL_ZERO, ST_OK);
        table_row(ACT_EXTRACT, VAL_ZERO,       1'b0, VAL_ZERO, ST_OK);
        table_row(ACT_EXTRACT, VAL_ZERO,       1'b1, VAL_ZERO, ST_EMPTY);
        table_row(ACT_FINDMIN, VAL_ZERO,       1'b0, VAL_ZERO, ST_OK);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (op_table[k])
            issue_op(op_table[k].action, op_table[k].value, op_table[k].fixed,
                     op_table[k].exp_value, op_table[k].exp_status);

        // sender gaps per phase; the receiver cannot stall so its share is dropped
        for (int phase = 0; phase < N_PHASES; phase++) begin
            case (phase)
                1:       idle_pct = 71;
                3:       idle_pct = 24;
                default: idle_pct = 0;
            endcase
            repeat (N_RANDOM / N_PHASES) random_op();
        end
        start <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
